// File: rtl/sida_pkg.sv
`default_nettype none

package sida_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CHAR_W    = 6;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned IDX_W     = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // ceil(2^35 / 10): q = (x * RECIP_10) >> 35 is exact for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
    } sida_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic out_free;
        logic last_pending;
    } sida_status_t;

endpackage

`default_nettype wire

// File: rtl/sida_if.sv
`default_nettype none

interface sida_num_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sida_char_if;
    logic        valid;
    logic        ready;
    logic [5:0]  character;
    logic        last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/sida_datapath.sv
`default_nettype none

module sida_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sida_pkg::sida_cmd_t                   cmd,
    output sida_pkg::sida_status_t                status,
    input  logic signed [sida_pkg::VALUE_W-1:0]   value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sida_pkg::CHAR_W-1:0]           character,
    output logic                                  last_char
);
    import sida_pkg::*;

    logic [VALUE_W-1:0]   mag_reg;
    logic [DIGIT_W-1:0]   digit_reg [MAX_DIGITS];
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 sign_pending_reg;
    logic                 sign_pending_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [DIGIT_W-1:0]   q_times_ten;
    logic [DIGIT_W-1:0]   rem;
    logic [VALUE_W-1:0]   abs_value;
    logic [CHAR_W-1:0]    emit_char;
    logic                 emit_last;

    // divide by ten through the reciprocal, remainder from the low bits only
    assign prod        = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_10};
    assign quot        = {{(RECIP_SHIFT - VALUE_W){1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
    assign q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem         = mag_reg[DIGIT_W-1:0] - q_times_ten;

    assign abs_value = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

    assign emit_char = sign_pending_reg ? CHAR_MINUS
                                        : (CHAR_ZERO + {2'b00, digit_reg[idx_reg]});
    assign emit_last = !sign_pending_reg && (idx_reg == '0);

    assign status.conv_last    = (quot == '0) || (idx_reg == IDX_W'(MAX_DIGITS - 1));
    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.last_pending = emit_last;

    always_comb
    begin
        idx_next          = idx_reg;
        sign_pending_next = sign_pending_reg;
        out_valid_next    = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            idx_next          = '0;
            sign_pending_next = value[VALUE_W-1];
        end
        else if (cmd.step)
        begin
            if (!status.conv_last)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (cmd.push)
        begin
            out_valid_next = 1'b1;
            if (sign_pending_reg)
            begin
                sign_pending_next = 1'b0;
            end
            else if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            sign_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            idx_reg          <= idx_next;
            sign_pending_reg <= sign_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= abs_value;
        end
        else if (cmd.step)
        begin
            mag_reg            <= quot;
            digit_reg[idx_reg] <= rem;
        end
        if (cmd.push)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(MAX_DIGITS - 1))
        else $error("digit index out of range");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == CHAR_MINUS) ||
                          ((char_reg >= CHAR_ZERO) && (char_reg <= CHAR_ZERO + 6'd9)))
        else $error("illegal character");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign marked as last");

endmodule

`default_nettype wire

// File: rtl/sida_ctrl.sv
`default_nettype none

module sida_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output sida_pkg::sida_cmd_t     cmd,
    input  sida_pkg::sida_status_t  status
);
    import sida_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.load   = in_ready && in_valid;
        cmd.step   = (state_reg == ST_CONV);
        cmd.push   = (state_reg == ST_EMIT) && status.out_free;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.conv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.push && status.last_pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_CONV)
        else $error("accepted item did not start conversion");

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
// an accepted item's nd digits are converted (nd = digit count, 1..10), then its characters
// are pushed, minus sign first when negative; one digit per cycle through the divide-by-ten
//   reciprocal multiplier, then one character per cycle out of the digit file when not stalled
// the output register lets the next item be accepted while the final character waits
// reset: rst_n asynchronous active low, clears controller state and output valid
`default_nettype none

module signed_int_to_decimal_ascii (
    input  logic              clk,
    input  logic              rst_n,
    sida_num_if.sink          number,
    sida_char_if.source       text
);
    import sida_pkg::*;

    // command and status between controller and datapath
    sida_cmd_t    cmd;
    sida_status_t status;

    // controller: idle -> convert (one digit per cycle, lsb first) -> emit (msb first)
    sida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: magnitude register, digit file, output item register
    sida_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (number.value),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .character (text.character),
        .last_char (text.last_char)
    );

endmodule

`default_nettype wire
